[design/cpr_pkg.sv]
// ----------------------------------------------------------------------------
// cpr_pkg: shared types and constants for the clock page replacement block
// state codes, result status codes, cell command and row status structs
// ----------------------------------------------------------------------------
package cpr_pkg;

	// controller states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_LOOK  = 4'b0010,
		ST_MISS  = 4'b0100,
		ST_SWEEP = 4'b1000
	} cpr_state_t;

	// result status codes
	typedef enum logic [1:0] {
		STATUS_HIT     = 2'd0,
		STATUS_FILL    = 2'd1,
		STATUS_REPLACE = 2'd2
	} cpr_status_t;

	// register map (index taken from paddr[2])
	localparam logic [0:0] REG_FRAMES_IN_USE = 1'b0;
	localparam logic [3:0] FRAMES_IN_USE_RESET = 4'd8;

	// command broadcast to every cell of the row
	typedef struct packed {
		logic tok_load;   // place token at cell sel_idx
		logic tok_step;   // token moves one cell up the row
		logic set_ref;    // token cell sets its reference bit
		logic clr_ref;    // token cell clears its reference bit
		logic wr_tok;     // token cell takes the page, ref set
		logic wr_idx;     // cell sel_idx takes the page, ref set
	} cpr_cell_cmd_t;

	// flags of the cell that holds the token
	typedef struct packed {
		logic hit_any;
		logic ref_any;
	} cpr_row_stat_t;

endpackage

[design/cpr_cell.sv]
// ----------------------------------------------------------------------------
// cpr_cell: one resident frame
// holds page, reference bit and the scan token, passes the token up the row
// ----------------------------------------------------------------------------
module cpr_cell #(
	parameter int IDX     = 0,
	parameter int IDX_W   = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cpr_pkg::cpr_cell_cmd_t cmd,
	input  logic [IDX_W-1:0]      sel_idx,
	input  logic [7:0]            page,
	input  logic                  tok_in,
	output logic                  tok_out,
	output logic                  hit,
	output logic                  ref_hit
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic [7:0] page_q;
	logic       ref_q;
	logic       tok_q;
	logic       wr;

	assign wr      = (cmd.wr_tok && tok_q) || (cmd.wr_idx && sel_idx == MY_IDX);
	assign tok_out = tok_q;
	assign hit     = tok_q && (page_q == page);
	assign ref_hit = tok_q && ref_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= 1'b0;
			tok_q <= 1'b0;
		end else begin
			if (wr || (cmd.set_ref && tok_q)) begin
				ref_q <= 1'b1;
			end else if (cmd.clr_ref && tok_q) begin
				ref_q <= 1'b0;
			end
			if (cmd.tok_load) begin
				tok_q <= (sel_idx == MY_IDX);
			end else if (cmd.tok_step) begin
				tok_q <= tok_in;
			end
		end
	end

	// page storage needs no reset: occupancy comes from the fill count
	always_ff @(posedge clk) begin
		if (wr) begin
			page_q <= page;
		end
	end

endmodule

[design/cpr_ctrl.sv]
// ----------------------------------------------------------------------------
// cpr_ctrl: sequencer for the clock page replacement row
// drives the token walk for lookup and sweep, keeps counts and the result word
// ----------------------------------------------------------------------------
module cpr_ctrl #(
	parameter int FRAMES = 8,
	parameter int IDX_W  = 3,
	parameter int CNT_W  = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [3:0]             frames_in_use,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             page,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             status,
	output logic [2:0]             slot,
	output logic [2:0]             hand,
	output logic [31:0]            hit_total,
	output logic [31:0]            fault_total,
	output logic [31:0]            replace_total,
	output cpr_pkg::cpr_cell_cmd_t cmd,
	output logic [IDX_W-1:0]       sel_idx,
	output logic [7:0]             pg,
	input  cpr_pkg::cpr_row_stat_t row
);

	cpr_pkg::cpr_state_t  state_q, state_n;
	cpr_pkg::cpr_status_t status_q, status_n;

	logic [7:0]       pg_q;
	logic [CNT_W-1:0] n_q, used_q, filled_q, filled_n;
	logic [IDX_W-1:0] pos_q, pos_n, clock_pos_q, clock_pos_n;
	logic [IDX_W-1:0] slot_q, slot_n, start_idx, pos_inc;
	logic [31:0]      hits_q, faults_q, repl_q;
	logic             hit_inc, fault_inc, repl_inc;
	logic             out_valid_q, out_set, out_free, accept;
	logic [CNT_W-1:0] n_c, used_c, pos_ext;
	logic             last_used, last_n;
	logic [IDX_W+2:0] slot_wide, hand_wide;

	// effective frame count: zero reads as one, clamp at the built count
	always_comb begin
		if (frames_in_use == 4'd0) begin
			n_c = CNT_W'(1);
		end else if (32'(frames_in_use) > FRAMES) begin
			n_c = CNT_W'(FRAMES);
		end else begin
			n_c = CNT_W'(frames_in_use);
		end
		used_c = (filled_q < n_c) ? filled_q : n_c;
	end

	assign accept    = in_valid && (state_q == cpr_pkg::ST_IDLE);
	assign in_stall  = (state_q != cpr_pkg::ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign pos_ext   = CNT_W'(pos_q);
	assign last_used = (pos_ext + CNT_W'(1)) == used_q;
	assign last_n    = (pos_ext + CNT_W'(1)) == n_q;
	assign pos_inc   = IDX_W'(pos_ext + CNT_W'(1));
	assign start_idx = (CNT_W'(clock_pos_q) < n_q) ? clock_pos_q : '0;

	always_comb begin
		state_n     = state_q;
		status_n    = status_q;
		slot_n      = slot_q;
		pos_n       = pos_q;
		filled_n    = filled_q;
		clock_pos_n = clock_pos_q;
		hit_inc     = 1'b0;
		fault_inc   = 1'b0;
		repl_inc    = 1'b0;
		out_set     = 1'b0;
		cmd         = '0;
		sel_idx     = '0;
		case (state_q)
			cpr_pkg::ST_IDLE: begin
				if (accept) begin
					if (used_c == '0) begin
						state_n = cpr_pkg::ST_MISS;
					end else begin
						cmd.tok_load = 1'b1;
						pos_n        = '0;
						state_n      = cpr_pkg::ST_LOOK;
					end
				end
			end
			cpr_pkg::ST_LOOK: begin
				if (row.hit_any) begin
					if (out_free) begin
						cmd.set_ref = 1'b1;
						status_n    = cpr_pkg::STATUS_HIT;
						slot_n      = pos_q;
						hit_inc     = 1'b1;
						out_set     = 1'b1;
						state_n     = cpr_pkg::ST_IDLE;
					end
				end else if (last_used) begin
					state_n = cpr_pkg::ST_MISS;
				end else begin
					cmd.tok_step = 1'b1;
					pos_n        = pos_inc;
				end
			end
			cpr_pkg::ST_MISS: begin
				if (filled_q < n_q) begin
					if (out_free) begin
						cmd.wr_idx = 1'b1;
						sel_idx    = filled_q[IDX_W-1:0];
						status_n   = cpr_pkg::STATUS_FILL;
						slot_n     = filled_q[IDX_W-1:0];
						filled_n   = filled_q + CNT_W'(1);
						fault_inc  = 1'b1;
						out_set    = 1'b1;
						state_n    = cpr_pkg::ST_IDLE;
					end
				end else begin
					cmd.tok_load = 1'b1;
					sel_idx      = start_idx;
					pos_n        = start_idx;
					state_n      = cpr_pkg::ST_SWEEP;
				end
			end
			cpr_pkg::ST_SWEEP: begin
				if (row.ref_any) begin
					cmd.clr_ref = 1'b1;
					if (last_n) begin
						cmd.tok_load = 1'b1;
						pos_n        = '0;
					end else begin
						cmd.tok_step = 1'b1;
						pos_n        = pos_inc;
					end
				end else if (out_free) begin
					cmd.wr_tok  = 1'b1;
					status_n    = cpr_pkg::STATUS_REPLACE;
					slot_n      = pos_q;
					clock_pos_n = last_n ? '0 : pos_inc;
					fault_inc   = 1'b1;
					repl_inc    = 1'b1;
					out_set     = 1'b1;
					state_n     = cpr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = cpr_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cpr_pkg::ST_IDLE;
			filled_q    <= '0;
			clock_pos_q <= '0;
			hits_q      <= '0;
			faults_q    <= '0;
			repl_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			filled_q    <= filled_n;
			clock_pos_q <= clock_pos_n;
			if (hit_inc && hits_q != '1) begin
				hits_q <= hits_q + 32'd1;
			end
			if (fault_inc && faults_q != '1) begin
				faults_q <= faults_q + 32'd1;
			end
			if (repl_inc && repl_q != '1) begin
				repl_q <= repl_q + 32'd1;
			end
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pg_q   <= page;
			n_q    <= n_c;
			used_q <= used_c;
		end
		pos_q    <= pos_n;
		status_q <= status_n;
		slot_q   <= slot_n;
	end

	assign slot_wide = {3'b000, slot_q};
	assign hand_wide = {3'b000, clock_pos_q};

	assign pg            = pg_q;
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign slot          = slot_wide[2:0];
	assign hand          = hand_wide[2:0];
	// counts only move when the result word is free, so they hold with it
	assign hit_total     = hits_q;
	assign fault_total   = faults_q;
	assign replace_total = repl_q;

endmodule

[design/clock_page_replacement.sv]
// ----------------------------------------------------------------------------
// clock_page_replacement: second-chance clock page replacement
// operation: a lookup walks the token from frame 0 through the used frames; a hit
//   ends it, a miss fills the next free frame or sweeps from the hand, clearing
//   reference bits until a frame with a clear bit is replaced
// throughput: one word at a time; the next word is taken the cycle after a result
//   is registered, and the token walks one frame per cycle
// reset: all frames empty, reference bits, hand and counts zero, frames_in_use 8
// ----------------------------------------------------------------------------
module clock_page_replacement #(
	parameter int FRAMES = 8   // built frame count, 1..8
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// reference input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  page,
	// result output
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [2:0]  slot,
	output logic [2:0]  hand,
	output logic [31:0] hit_total,
	output logic [31:0] fault_total,
	output logic [31:0] replace_total
);

	// frame index width and fill count width (count reaches FRAMES)
	localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CNT_W = $clog2(FRAMES + 1);

	logic [3:0]             frames_in_use_q;
	cpr_pkg::cpr_cell_cmd_t cmd;
	cpr_pkg::cpr_row_stat_t row;
	logic [IDX_W-1:0]       sel_idx;
	logic [7:0]             pg;
	logic [FRAMES-1:0]      tok, hit_v, ref_v;

	// register file: only frames_in_use, upper address word is ignored
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= cpr_pkg::FRAMES_IN_USE_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == cpr_pkg::REG_FRAMES_IN_USE) begin
			frames_in_use_q <= pwdata[3:0];
		end
	end

	// reads decode the full word address, anything else reads as zero
	assign prdata = (paddr[2] == cpr_pkg::REG_FRAMES_IN_USE && paddr[1:0] == 2'b00)
		? {28'd0, frames_in_use_q} : 32'd0;

	// sequencer: accepts a reference, walks the token through the row for the
	// lookup, then fills the next free frame or sweeps the clock hand
	cpr_ctrl #(
		.FRAMES (FRAMES),
		.IDX_W  (IDX_W),
		.CNT_W  (CNT_W)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.frames_in_use (frames_in_use_q),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.page          (page),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.slot          (slot),
		.hand          (hand),
		.hit_total     (hit_total),
		.fault_total   (fault_total),
		.replace_total (replace_total),
		.cmd           (cmd),
		.sel_idx       (sel_idx),
		.pg            (pg),
		.row           (row)
	);

	// row of frame cells; the token enters at cell 0 only by a load, and the
	// sequencer reloads it at cell 0 when the hand wraps past the last frame
	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		logic tok_in;
		if (i == 0) begin : g_first
			assign tok_in = 1'b0;
		end else begin : g_next
			assign tok_in = tok[i-1];
		end
		cpr_cell #(
			.IDX   (i),
			.IDX_W (IDX_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.sel_idx (sel_idx),
			.page    (pg),
			.tok_in  (tok_in),
			.tok_out (tok[i]),
			.hit     (hit_v[i]),
			.ref_hit (ref_v[i])
		);
	end

	// only the token cell can raise a flag, so an or over the row selects it
	assign row.hit_any = |hit_v;
	assign row.ref_any = |ref_v;

endmodule

[tb/tb_clock_page_replacement.sv]
// ----------------------------------------------------------------------------
// tb_clock_page_replacement: self-checking bench for the clock page replacer
// a scripted opening covers fills, hits, sweeps, clamped and ignored register
// writes and a hand past the frame count; random phases then run working-set
// references under many frame counts, checked word by word against a
// behavioral second-chance predictor, with random gaps and stalls
// ----------------------------------------------------------------------------
module tb_clock_page_replacement;

	localparam int FRAMES        = 8;
	localparam int NUM_PHASES    = 11;
	localparam int PHASE_ITEMS   = 41;
	localparam int PRESSURE_PHASE = 3;
	localparam int HOLD_CYCLES   = 120;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 25;
	localparam int QUIET_LIMIT   = 2000;
	localparam logic [2:0] ADDR_FRAMES = 3'd0;   // register index 0
	localparam logic [2:0] ADDR_UNUSED = 3'd4;   // register index 1, not mapped

	// one result word as the block reports it
	typedef struct packed {
		cpr_pkg::cpr_status_t st;
		logic [2:0]  slot;
		logic [2:0]  hand;
		logic [31:0] hits;
		logic [31:0] faults;
		logic [31:0] evicts;
	} page_result_t;

	typedef enum logic [1:0] {ROW_REF, ROW_CHECKED, ROW_WRITE} row_kind_t;

	// one row of the opening script
	typedef struct {
		row_kind_t    kind;
		logic [2:0]   addr;
		logic [31:0]  data;
		logic [7:0]   pg;
		page_result_t want;
	} script_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  page;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [2:0]  slot;
	logic [2:0]  hand;
	logic [31:0] hit_total;
	logic [31:0] fault_total;
	logic [31:0] replace_total;

	// shadow of the block's frames, hand, counts and register
	logic [7:0]  frame_page [FRAMES];
	bit          frame_ref [FRAMES];
	int          frames_filled;
	int          clock_hand;
	logic [31:0] hit_count;
	logic [31:0] fault_count;
	logic [31:0] evict_count;
	logic [3:0]  frames_cfg;
	int          fill_seen;

	page_result_t expected_q [$];
	script_row_t  script [$];
	int           fail_count;
	int           words_checked;

	// idle controls shared by the sender, the receiver and the main sequence
	bit send_idle;
	bit recv_idle;
	bit hold_req;

	clock_page_replacement #(.FRAMES(FRAMES)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.page          (page),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.slot          (slot),
		.hand          (hand),
		.hit_total     (hit_total),
		.fault_total   (fault_total),
		.replace_total (replace_total)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [31:0] bump(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	// effective frame count: zero acts as one, anything past the build clamps
	function automatic int active_frames(input logic [3:0] cfg);
		if (cfg == 4'd0)
			return 1;
		if (cfg > FRAMES)
			return FRAMES;
		return int'(cfg);
	endfunction

	// second-chance step: updates the shadow state and returns the result word
	function automatic page_result_t clock_lookup(input logic [7:0] pg);
		page_result_t r;
		int n;
		int used;
		int pos;
		int i;
		bit found;
		n = active_frames(frames_cfg);
		used = (frames_filled < n) ? frames_filled : n;
		found = 1'b0;
		pos = 0;
		// only occupied frames below the active count may match
		for (i = 0; i < used; i++) begin
			if (!found && frame_page[i] == pg) begin
				found = 1'b1;
				pos = i;
			end
		end
		if (found) begin
			r.st = cpr_pkg::STATUS_HIT;
			frame_ref[pos] = 1'b1;
			hit_count = bump(hit_count);
		end else if (frames_filled < n) begin
			r.st = cpr_pkg::STATUS_FILL;
			pos = frames_filled;
			frame_page[pos] = pg;
			frame_ref[pos] = 1'b1;
			frames_filled++;
			fault_count = bump(fault_count);
			fill_seen++;
		end else begin
			r.st = cpr_pkg::STATUS_REPLACE;
			// a hand left past a lowered count restarts at frame zero
			pos = (clock_hand < n) ? clock_hand : 0;
			while (frame_ref[pos]) begin
				frame_ref[pos] = 1'b0;
				pos = (pos + 1) % n;
			end
			frame_page[pos] = pg;
			frame_ref[pos] = 1'b1;
			clock_hand = (pos + 1) % n;
			fault_count = bump(fault_count);
			evict_count = bump(evict_count);
		end
		r.slot   = 3'(pos);
		r.hand   = 3'(clock_hand);
		r.hits   = hit_count;
		r.faults = fault_count;
		r.evicts = evict_count;
		return r;
	endfunction

	function automatic page_result_t typed_result(input cpr_pkg::cpr_status_t st,
		input int sl, input int hd, input int h, input int f, input int e);
		page_result_t r;
		r.st = st;
		r.slot = 3'(sl);
		r.hand = 3'(hd);
		r.hits = 32'(h);
		r.faults = 32'(f);
		r.evicts = 32'(e);
		return r;
	endfunction

	function automatic void add_ref(input logic [7:0] pg);
		script_row_t row;
		row.kind = ROW_REF;
		row.addr = '0;
		row.data = '0;
		row.pg = pg;
		row.want = '0;
		script.insert(script.size(), row);
	endfunction

	function automatic void add_checked(input logic [7:0] pg, input page_result_t want);
		script_row_t row;
		row.kind = ROW_CHECKED;
		row.addr = '0;
		row.data = '0;
		row.pg = pg;
		row.want = want;
		script.insert(script.size(), row);
	endfunction

	function automatic void add_write(input logic [2:0] addr, input logic [31:0] data);
		script_row_t row;
		row.kind = ROW_WRITE;
		row.addr = addr;
		row.data = data;
		row.pg = '0;
		row.want = '0;
		script.insert(script.size(), row);
	endfunction

	// opening script: typed rows are plain enough to read off by hand
	function automatic void build_script();
		int k;
		// two fills at the page extremes, then a hit, with 8 frames from reset
		add_checked(8'h00, typed_result(cpr_pkg::STATUS_FILL, 0, 0, 0, 1, 0));
		add_checked(8'hFF, typed_result(cpr_pkg::STATUS_FILL, 1, 0, 0, 2, 0));
		add_checked(8'h00, typed_result(cpr_pkg::STATUS_HIT, 0, 0, 1, 2, 0));
		// write to the unmapped register index must change nothing
		add_write(ADDR_UNUSED, 32'h0000_0001);
		// two frames, both referenced: sweep clears both and takes frame 0
		add_write(ADDR_FRAMES, 32'd2);
		add_checked(8'h55, typed_result(cpr_pkg::STATUS_REPLACE, 0, 1, 1, 3, 1));
		add_checked(8'hFF, typed_result(cpr_pkg::STATUS_HIT, 1, 1, 2, 3, 1));
		add_checked(8'hAA, typed_result(cpr_pkg::STATUS_REPLACE, 1, 0, 2, 4, 2));
		// zero acts as one frame; frame 1 holds 0xaa but sits above the count
		add_write(ADDR_FRAMES, 32'd0);
		add_checked(8'h55, typed_result(cpr_pkg::STATUS_HIT, 0, 0, 3, 4, 2));
		add_checked(8'hAA, typed_result(cpr_pkg::STATUS_REPLACE, 0, 0, 3, 5, 3));
		// fifteen clamps to the built count
		add_write(ADDR_FRAMES, 32'd15);
		add_checked(8'hAA, typed_result(cpr_pkg::STATUS_HIT, 0, 0, 4, 5, 3));
		add_checked(8'h12, typed_result(cpr_pkg::STATUS_FILL, 2, 0, 4, 6, 3));
		// fill the rest, then walk the hand up to frame 5
		for (k = 0; k < 5; k++)
			add_ref(8'h13 + 8'(k));
		for (k = 0; k < 5; k++)
			add_ref(8'h80 + 8'(k));
		// lower the count below the hand: the next sweep starts at frame 0
		add_write(ADDR_FRAMES, 32'd3);
		add_ref(8'h85);
		add_ref(8'h84);
		add_write(ADDR_FRAMES, 32'd1);
		add_ref(8'h01);
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// offer one reference word; called and returns at a falling edge
	task automatic send_page(input logic [7:0] pg, input bit typed, input page_result_t want);
		page_result_t got;
		if (send_idle && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		in_valid <= 1'b1;
		page <= pg;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		// accepted: the shadow state always advances, typed rows supply the word
		got = clock_lookup(pg);
		expected_q.insert(expected_q.size(), typed ? want : got);
		@(negedge clk);
	endtask

	// setup and access phases; returns at a falling edge once the bus has gone quiet
	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		forever begin
			@(posedge clk);
			if (pready)
				break;
		end
		if (addr[2] == cpr_pkg::REG_FRAMES_IN_USE)
			frames_cfg = data[3:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// let every outstanding word come back before touching the register
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// main sequence: reset, scripted opening, random phases, drain
	initial begin : stimulus
		int phase_frames [NUM_PHASES];
		logic [7:0] pool [12];
		logic [7:0] pg;
		int ph;
		int k;
		int span;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		page = '0;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		hold_req = 1'b0;
		fail_count = 0;
		words_checked = 0;
		fill_seen = 0;
		for (k = 0; k < FRAMES; k++) begin
			frame_page[k] = '0;
			frame_ref[k] = 1'b0;
		end
		frames_filled = 0;
		clock_hand = 0;
		hit_count = '0;
		fault_count = '0;
		evict_count = '0;
		frames_cfg = cpr_pkg::FRAMES_IN_USE_RESET;
		phase_frames = '{8, 1, 3, 15, 5, 0, 2, 8, 6, 4, 7};
		for (k = 0; k < 12; k++)
			pool[k] = 8'($urandom);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		build_script();
		foreach (script[k]) begin
			case (script[k].kind)
				ROW_WRITE: begin
					settle();
					apb_write(script[k].addr, script[k].data);
				end
				ROW_REF: begin
					send_page(script[k].pg, 1'b0, '0);
				end
				default: begin
					send_page(script[k].pg, 1'b1, script[k].want);
				end
			endcase
		end

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			settle();
			// stray writes to the unmapped index, random upper data bits on the real one
			if ($urandom_range(0, 2) == 0)
				apb_write(ADDR_UNUSED, $urandom);
			apb_write(ADDR_FRAMES, ($urandom & 32'hFFFF_FFF0) | 32'(phase_frames[ph]));
			if (ph == PRESSURE_PHASE) begin
				// receiver holds off while the sender keeps pushing back to back
				send_idle = 1'b0;
				hold_req = 1'b1;
			end
			if (ph == NUM_PHASES - 1) begin
				send_idle = 1'b0;
				recv_idle = 1'b0;
			end
			// working set a little larger than the frame count, partly carried over
			for (k = 0; k < 12; k++)
				if ($urandom_range(0, 1) == 0)
					pool[k] = 8'($urandom);
			span = active_frames(phase_frames[ph][3:0]) + 2;
			if (span > 12)
				span = 12;
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(0, 3) != 0)
					pg = pool[$urandom_range(0, span - 1)];
				else
					pg = 8'($urandom);
				send_page(pg, 1'b0, '0);
			end
			if (ph == PRESSURE_PHASE)
				send_idle = 1'b1;
		end

		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("checked %0d result words: %0d hits, %0d fills, %0d replacements",
			words_checked, hit_count, fill_seen, evict_count);
		$display("frame counts 0 through 8 and 15 written, unmapped index writes, long output hold");
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin : receiver
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
			end else if (recv_idle && arst_n && $urandom_range(0, 6) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// result checker: each accepted word against the oldest expectation
	always @(posedge clk) begin : result_check
		page_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$error("result word with nothing expected: status %0d slot %0d", status, slot);
				fail_count++;
			end else begin
				want = expected_q.pop_front();
				compare_field("status", 32'(want.st), 32'(status));
				compare_field("slot", 32'(want.slot), 32'(slot));
				compare_field("hand", 32'(want.hand), 32'(hand));
				compare_field("hit_total", want.hits, hit_total);
				compare_field("fault_total", want.faults, fault_total);
				compare_field("replace_total", want.evicts, replace_total);
				words_checked++;
			end
		end
	end

	// watchdog: too long with no word moving on any port ends the run
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
		$display("FAIL");
		$finish;
	end

endmodule

[sim.f]
design/cpr_pkg.sv
design/cpr_cell.sv
design/cpr_ctrl.sv
design/clock_page_replacement.sv
tb/tb_clock_page_replacement.sv
